@@ rtl/buzzer_alert_pattern_sequencer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// buzzer alert pattern sequencer: assertion macros
// concurrent checks used by the port checker
// ----------------------------------------------------------------------------
`ifndef BUZZER_ALERT_PATTERN_SEQUENCER_UNIT_DEFINES_SVH
`define BUZZER_ALERT_PATTERN_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define BZAP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bzap check failed");

// next-cycle implication
`define BZAP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bzap check failed");

`endif

@@ rtl/bzap_pkg.sv @@
// ----------------------------------------------------------------------------
// bzap_pkg
// shared types, codes and the pattern rom of the buzzer alert sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bzap_pkg;

   localparam int QUEUE_DEPTH_DEF   = 12;
   localparam int RECOVER_COUNT_DEF = 3;

   localparam int EV_W    = 4;
   localparam int LEVEL_W = 4;
   localparam int MS_W    = 8;

   // item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_PLAY  = 2'd1;
   localparam logic [1:0] KIND_FAULT = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // request status
   localparam logic [1:0] ST_QUEUED  = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;
   localparam logic [1:0] ST_FLUSHED = 2'd3;

   // csr indexes
   localparam logic [1:0] CSR_MUTED     = 2'd0;
   localparam logic [1:0] CSR_CLICK_GAP = 2'd1;
   localparam logic [1:0] CSR_REPEAT    = 2'd2;

   localparam logic [15:0] CLICK_GAP_RST = 16'd80;
   localparam logic [15:0] REPEAT_RST    = 16'd15000;

   // events
   localparam logic [EV_W-1:0] EV_CLICK   = 4'd0;
   localparam logic [EV_W-1:0] EV_BOOT    = 4'd1;
   localparam logic [EV_W-1:0] EV_SUCCESS = 4'd2;
   localparam logic [EV_W-1:0] EV_ERROR   = 4'd3;
   localparam logic [EV_W-1:0] EV_E01     = 4'd4;
   localparam logic [EV_W-1:0] EV_E02     = 4'd5;
   localparam logic [EV_W-1:0] EV_E03     = 4'd6;
   localparam logic [EV_W-1:0] EV_E04     = 4'd7;
   localparam logic [EV_W-1:0] EV_E05     = 4'd8;
   localparam logic [EV_W-1:0] EV_E06     = 4'd9;
   localparam logic [EV_W-1:0] EV_RECOVER = 4'd10;
   localparam logic [EV_W-1:0] EV_COUNT   = 4'd11;

   localparam logic [7:0] FAULT_NORMAL   = 8'd0;
   localparam logic [7:0] FAULT_KNOWN_LO = 8'd1;
   localparam logic [7:0] FAULT_KNOWN_HI = 8'd6;
   localparam logic [EV_W-1:0] FAULT_EV_OFFSET = 4'd3;

   typedef struct packed {
      logic [MS_W-1:0] on_ms;
      logic [MS_W-1:0] off_ms;
   } seg_type;

   typedef struct packed {
      logic            valid;
      logic            flush;
      logic [EV_W-1:0] ev;
   } push_cmd_type;

   typedef struct packed {
      logic            start;
      logic [EV_W-1:0] ev;
   } start_cmd_type;

   typedef struct packed {
      logic idle;
      logic fin;
   } player_stat_type;

   typedef struct packed {
      logic busy;
      logic off;
   } player_next_type;

   typedef struct packed {
      logic               buzzer_on;
      logic               player_busy;
      logic [LEVEL_W-1:0] queue_level;
      logic [1:0]         request_status;
   } result_type;

   function automatic logic is_low_priority(input logic [EV_W-1:0] ev);
      return (ev == EV_CLICK) || (ev == EV_BOOT) || (ev == EV_SUCCESS) ||
             (ev == EV_RECOVER);
   endfunction

   // index of the last segment of each pattern
   function automatic logic [1:0] rom_last(input logic [EV_W-1:0] pat);
      logic [1:0] last;
      case (pat) inside
         EV_BOOT, EV_SUCCESS, EV_E02, EV_E03, EV_RECOVER: last = 2'd1;
         EV_E01, EV_E05, EV_E06:                          last = 2'd2;
         EV_E04:                                          last = 2'd3;
         default:                                         last = 2'd0;
      endcase
      return last;
   endfunction

   // on/off lengths in ms; every on phase in the table is nonzero
   function automatic seg_type rom_seg(input logic [EV_W-1:0] pat, input logic [1:0] seg);
      seg_type s;
      s = '{on_ms: 8'd0, off_ms: 8'd0};
      case (pat)
         EV_CLICK:   if (seg == 2'd0) s = '{8'd30, 8'd0};
         EV_BOOT:    s = (seg == 2'd0) ? '{8'd60, 8'd80} : '{8'd60, 8'd0};
         EV_SUCCESS: s = (seg == 2'd0) ? '{8'd40, 8'd60} : '{8'd40, 8'd0};
         EV_ERROR:   if (seg == 2'd0) s = '{8'd180, 8'd0};
         EV_E01:     s = (seg == 2'd2) ? '{8'd80, 8'd0} : '{8'd80, 8'd80};
         EV_E02:     s = (seg == 2'd0) ? '{8'd180, 8'd120} : '{8'd180, 8'd0};
         EV_E03:     s = (seg == 2'd0) ? '{8'd120, 8'd120} : '{8'd120, 8'd0};
         EV_E04:     s = (seg == 2'd3) ? '{8'd80, 8'd0} : '{8'd80, 8'd80};
         EV_E05:     s = (seg == 2'd2) ? '{8'd120, 8'd0} : '{8'd120, 8'd100};
         EV_E06: begin
            case (seg)
               2'd0:    s = '{8'd80, 8'd70};
               2'd1:    s = '{8'd80, 8'd120};
               default: s = '{8'd220, 8'd0};
            endcase
         end
         EV_RECOVER: s = (seg == 2'd0) ? '{8'd40, 8'd80} : '{8'd40, 8'd0};
         default:    s = '{8'd0, 8'd0};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bzap_front.sv @@
// ----------------------------------------------------------------------------
// bzap_front
// classifies items: time base, click filter, fault tracking, queue decision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bzap_front import bzap_pkg::*; #(
   parameter int RECOVER_COUNT = RECOVER_COUNT_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [1:0]   kind,
   input  wire logic [3:0]   play_event,
   input  wire logic [7:0]   alarm_code,
   input  wire logic         muted,
   input  wire logic [15:0]  click_gap,
   input  wire logic [15:0]  repeat_limit,
   input  wire logic         q_full,
   output push_cmd_type      push_cmd,
   output logic              tick,
   output logic [1:0]        status
);

   localparam int NC_W = $clog2(RECOVER_COUNT + 1);

   logic [31:0]      time_ff, time_in;
   logic             click_seen_ff, click_seen_in;
   logic [31:0]      last_click_ff, last_click_in;
   logic             fault_active_ff, fault_active_in;
   logic [7:0]       active_code_ff, active_code_in;
   logic [NC_W-1:0]  normal_cnt_ff, normal_cnt_in;
   logic [31:0]      last_beep_ff, last_beep_in;

   logic            is_play, is_fault, is_none;
   logic            code_zero, changed, due, recover, fault_req;
   logic [NC_W-1:0] nc_inc;
   logic [EV_W-1:0] fault_ev, req_ev;
   logic            req_valid, gap_block, ignored;

   always_comb begin
      tick     = accept && (kind == KIND_TICK);
      is_play  = accept && (kind == KIND_PLAY);
      is_fault = accept && (kind == KIND_FAULT);
      is_none  = accept && (kind == KIND_NONE);

      code_zero = (alarm_code == FAULT_NORMAL);
      nc_inc    = (normal_cnt_ff < NC_W'(RECOVER_COUNT)) ? normal_cnt_ff + 1'b1
                                                         : normal_cnt_ff;
      recover   = is_fault && code_zero && fault_active_ff &&
                  (nc_inc >= NC_W'(RECOVER_COUNT));
      changed   = !fault_active_ff || (active_code_ff != alarm_code);
      due       = (time_ff - last_beep_ff) >= {16'd0, repeat_limit};
      fault_req = is_fault && !code_zero && (changed || due);
      fault_ev  = (alarm_code >= FAULT_KNOWN_LO && alarm_code <= FAULT_KNOWN_HI)
                  ? alarm_code[EV_W-1:0] + FAULT_EV_OFFSET : EV_ERROR;

      req_valid = is_play || recover || fault_req;
      req_ev    = is_play ? play_event : (recover ? EV_RECOVER : fault_ev);

      gap_block = click_seen_ff && ((time_ff - last_click_ff) < {16'd0, click_gap});
      ignored   = (req_ev >= EV_COUNT) || muted || ((req_ev == EV_CLICK) && gap_block);

      time_in         = tick ? time_ff + 32'd1 : time_ff;
      click_seen_in   = click_seen_ff;
      last_click_in   = last_click_ff;
      fault_active_in = fault_active_ff;
      active_code_in  = active_code_ff;
      normal_cnt_in   = normal_cnt_ff;
      last_beep_in    = last_beep_ff;

      if (is_fault) begin
         if (code_zero) begin
            if (fault_active_ff) begin
               normal_cnt_in = nc_inc;
            end
            if (recover) begin
               fault_active_in = 1'b0;
               active_code_in  = FAULT_NORMAL;
            end
         end else begin
            fault_active_in = 1'b1;
            normal_cnt_in   = '0;
            active_code_in  = alarm_code;
            if (changed || due) begin
               last_beep_in = time_ff;
            end
         end
      end

      // an accepted click records its time even if the queue drops it
      if (req_valid && !ignored && (req_ev == EV_CLICK)) begin
         click_seen_in = 1'b1;
         last_click_in = time_ff;
      end

      push_cmd = '{valid: 1'b0, flush: 1'b0, ev: req_ev};
      status   = is_none ? ST_IGNORED : ST_QUEUED;
      if (req_valid) begin
         if (ignored) begin
            status = ST_IGNORED;
         end else if (!q_full) begin
            push_cmd.valid = 1'b1;
         end else if (is_low_priority(req_ev)) begin
            status = ST_DROPPED;
         end else begin
            status         = ST_FLUSHED;
            push_cmd.valid = 1'b1;
            push_cmd.flush = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff         <= '0;
         click_seen_ff   <= 1'b0;
         last_click_ff   <= '0;
         fault_active_ff <= 1'b0;
         active_code_ff  <= '0;
         normal_cnt_ff   <= '0;
         last_beep_ff    <= '0;
      end else begin
         time_ff         <= time_in;
         click_seen_ff   <= click_seen_in;
         last_click_ff   <= last_click_in;
         fault_active_ff <= fault_active_in;
         active_code_ff  <= active_code_in;
         normal_cnt_ff   <= normal_cnt_in;
         last_beep_ff    <= last_beep_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bzap_queue.sv @@
// ----------------------------------------------------------------------------
// bzap_queue
// request fifo between the classifier and the player, with flush and bypass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bzap_queue import bzap_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            muted,
   input  wire push_cmd_type    push_cmd,
   input  wire player_stat_type player_stat,
   output start_cmd_type        start_cmd,
   output logic                 full,
   output logic [LEVEL_W-1:0]   level_next
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [EV_W-1:0]  mem_ff [DEPTH];
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             we;
   logic [PTR_W-1:0] waddr;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      full      = (cnt_ff == CNT_W'(DEPTH));
      start_cmd = '{start: 1'b0, ev: push_cmd.ev};
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      cnt_in    = cnt_ff;
      we        = 1'b0;
      waddr     = wr_ff;

      if (push_cmd.valid) begin
         if (push_cmd.flush) begin
            we     = 1'b1;
            waddr  = rd_ff;
            wr_in  = ptr_inc(rd_ff);
            cnt_in = CNT_W'(1);
         end else if (player_stat.idle) begin
            // idle player implies an empty queue: start straight away
            start_cmd.start = 1'b1;
         end else begin
            we     = 1'b1;
            wr_in  = ptr_inc(wr_ff);
            cnt_in = cnt_ff + 1'b1;
         end
      end

      if (player_stat.fin) begin
         if (muted) begin
            // every waiting pattern ends at once without sound
            rd_in  = wr_ff;
            cnt_in = '0;
         end else if (cnt_ff != '0) begin
            start_cmd.start = 1'b1;
            start_cmd.ev    = mem_ff[rd_ff];
            rd_in           = ptr_inc(rd_ff);
            cnt_in          = cnt_ff - 1'b1;
         end
      end

      level_next = LEVEL_W'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= push_cmd.ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bzap_player.sv @@
// ----------------------------------------------------------------------------
// bzap_player
// steps through the on/off segments of the current pattern on each tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bzap_player import bzap_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          tick,
   input  wire logic          muted,
   input  wire start_cmd_type start_cmd,
   output player_stat_type    player_stat,
   output player_next_type    player_next
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_ON   = 3'b010,
      PH_OFF  = 3'b100
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [EV_W-1:0] pat_ff, pat_in;
   logic [1:0]      seg_ff, seg_in;
   logic [MS_W-1:0] rem_ff, rem_in;

   seg_type         cur_seg, nxt_seg, start_seg;
   logic [MS_W-1:0] rem_dec;
   logic            seg_done, fin;

   always_comb begin
      cur_seg   = rom_seg(pat_ff, seg_ff);
      nxt_seg   = rom_seg(pat_ff, seg_ff + 2'd1);
      start_seg = rom_seg(start_cmd.ev, 2'd0);
      rem_dec   = (rem_ff != '0) ? rem_ff - 1'b1 : '0;

      phase_in = phase_ff;
      pat_in   = pat_ff;
      seg_in   = seg_ff;
      rem_in   = rem_ff;
      seg_done = 1'b0;
      fin      = 1'b0;

      if (tick) begin
         unique case (phase_ff)
            PH_IDLE: ;
            PH_ON: begin
               if (rem_dec != '0) begin
                  rem_in = rem_dec;
               end else if (cur_seg.off_ms != '0) begin
                  phase_in = PH_OFF;
                  rem_in   = cur_seg.off_ms;
               end else begin
                  seg_done = 1'b1;
               end
            end
            PH_OFF: begin
               if (rem_dec != '0) begin
                  rem_in = rem_dec;
               end else begin
                  seg_done = 1'b1;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      if (seg_done) begin
         if ((seg_ff == rom_last(pat_ff)) || muted) begin
            fin      = 1'b1;
            phase_in = PH_IDLE;
            rem_in   = '0;
         end else begin
            seg_in   = seg_ff + 2'd1;
            phase_in = PH_ON;
            rem_in   = nxt_seg.on_ms;
         end
      end

      if (start_cmd.start) begin
         phase_in = PH_ON;
         pat_in   = start_cmd.ev;
         seg_in   = 2'd0;
         rem_in   = start_seg.on_ms;
      end

      player_stat = '{idle: (phase_ff == PH_IDLE), fin: fin};
      player_next = '{busy: (phase_in != PH_IDLE), off: (phase_in == PH_OFF)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pat_ff   <= '0;
         seg_ff   <= '0;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pat_ff   <= pat_in;
         seg_ff   <= seg_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/buzzer_alert_pattern_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// buzzer_alert_pattern_sequencer_unit
// a result word is registered in the output buffer as its item is accepted
// throughput: one item per cycle while the output buffer is not full
// a two-word output buffer keeps input flowing while one result waits
// reset is synchronous and clears all control state; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buzzer_alert_pattern_sequencer_unit import bzap_pkg::*; #(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int RECOVER_COUNT = RECOVER_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [3:0]  req_play_event,
   input  wire logic [7:0]  req_alarm_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_buzzer_on,
   output logic             rsp_player_busy,
   output logic [3:0]       rsp_queue_level,
   output logic [1:0]       rsp_request_status,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam logic [1:0] OBUF_FULL = 2'd2;

   logic        muted_ff, muted_in;
   logic [15:0] click_gap_ff, click_gap_in;
   logic [15:0] repeat_ff, repeat_in;

   logic            accept, tick, q_full;
   logic [1:0]      status;
   push_cmd_type    push_cmd;
   start_cmd_type   start_cmd;
   player_stat_type player_stat;
   player_next_type player_next;
   logic [LEVEL_W-1:0] level_next;

   result_type  res;
   result_type  slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]  ocnt_ff, ocnt_in;
   logic        do_pop;

   assign req_stall = (ocnt_ff == OBUF_FULL);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      muted_in     = muted_ff;
      click_gap_in = click_gap_ff;
      repeat_in    = repeat_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MUTED:     muted_in     = csr_wdata[0];
            CSR_CLICK_GAP: click_gap_in = csr_wdata;
            CSR_REPEAT:    repeat_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         muted_ff     <= 1'b0;
         click_gap_ff <= CLICK_GAP_RST;
         repeat_ff    <= REPEAT_RST;
      end else begin
         muted_ff     <= muted_in;
         click_gap_ff <= click_gap_in;
         repeat_ff    <= repeat_in;
      end
   end

   bzap_front #(
      .RECOVER_COUNT (RECOVER_COUNT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_kind),
      .play_event   (req_play_event),
      .alarm_code   (req_alarm_code),
      .muted        (muted_ff),
      .click_gap    (click_gap_ff),
      .repeat_limit (repeat_ff),
      .q_full       (q_full),
      .push_cmd     (push_cmd),
      .tick         (tick),
      .status       (status)
   );

   bzap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .muted       (muted_ff),
      .push_cmd    (push_cmd),
      .player_stat (player_stat),
      .start_cmd   (start_cmd),
      .full        (q_full),
      .level_next  (level_next)
   );

   bzap_player u_player (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .muted       (muted_ff),
      .start_cmd   (start_cmd),
      .player_stat (player_stat),
      .player_next (player_next)
   );

   // result word and two-entry output buffer
   always_comb begin
      res = '{buzzer_on:      player_next.busy && !player_next.off && !muted_ff,
              player_busy:    player_next.busy,
              queue_level:    level_next,
              request_status: status};

      do_pop   = rsp_valid && !rsp_stall;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      ocnt_in  = ocnt_ff;
      case ({accept, do_pop})
         2'b10: begin
            if (ocnt_ff == 2'd0) begin
               slot0_in = res;
            end else begin
               slot1_in = res;
            end
            ocnt_in = ocnt_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            ocnt_in  = ocnt_ff - 2'd1;
         end
         2'b11: begin
            // buffer held one word, which leaves now
            slot0_in = res;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= '0;
      end else begin
         ocnt_ff <= ocnt_in;
      end
   end

   assign rsp_valid          = (ocnt_ff != 2'd0);
   assign rsp_buzzer_on      = slot0_ff.buzzer_on;
   assign rsp_player_busy    = slot0_ff.player_busy;
   assign rsp_queue_level    = slot0_ff.queue_level;
   assign rsp_request_status = slot0_ff.request_status;

endmodule

`default_nettype wire

@@ rtl/bzap_checker.sv @@
// ----------------------------------------------------------------------------
// bzap_checker
// port-level checks on the result channel of the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "buzzer_alert_pattern_sequencer_unit_defines.svh"

module bzap_checker import bzap_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_buzzer_on,
   input wire logic       rsp_player_busy,
   input wire logic [3:0] rsp_queue_level,
   input wire logic [1:0] rsp_request_status
);

   // a waiting word stays put
   `BZAP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_queue_level) && $stable(rsp_request_status) && $stable(rsp_buzzer_on) && $stable(rsp_player_busy))

   // sound only while a pattern plays
   `BZAP_ASSERT_IMP(a_buzz_busy, clock, reset, rsp_valid && rsp_buzzer_on, rsp_player_busy)

   // an idle player never leaves requests waiting
   `BZAP_ASSERT_IMP(a_idle_empty, clock, reset, rsp_valid && !rsp_player_busy, rsp_queue_level == 4'd0)

   // a flush leaves just the new request, behind a running pattern
   `BZAP_ASSERT_IMP(a_flush_one, clock, reset, rsp_valid && (rsp_request_status == ST_FLUSHED), (rsp_queue_level == 4'd1) && rsp_player_busy)

endmodule

bind buzzer_alert_pattern_sequencer_unit bzap_checker u_bzap_checker (.*);

`default_nettype wire
